>>> hw/rtl/hrlf_pkg.sv
package hrlf_pkg;

    // Header size limit and derived counter widths.
    localparam int MAX_HEADER    = 512;
    localparam int HDR_OUT_W     = 9;
    localparam int HDR_CNT_W     = ($clog2(MAX_HEADER) > HDR_OUT_W) ?
                                   $clog2(MAX_HEADER) : HDR_OUT_W;
    localparam logic [HDR_CNT_W-1:0] HDR_LIMIT = HDR_CNT_W'(MAX_HEADER - 1);

    localparam int LEN_W         = 31;
    localparam int NUM_W         = 32;
    localparam logic [LEN_W-1:0] MAX_CONTENT_RESET = 31'd65536;

    // Key "content-length:" in lower case.
    localparam int KEY_LEN       = 15;
    localparam logic [3:0] KEY_LAST = 4'(KEY_LEN);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    // Last three header bytes that, followed by LF, end the header.
    localparam logic [23:0] TAIL_CRLFCR = 24'h0D0A0D;

    // Phase codes as seen on the result channel.
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;
    localparam logic [1:0] PH_ERROR  = 2'd3;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_HDR_LONG    = 2'd1,
        ERR_LEN_MISSING = 2'd2,
        ERR_LEN_INVALID = 2'd3
    } err_t;

    typedef enum logic [3:0] {
        ST_HEADER = 4'b0001,
        ST_BODY   = 4'b0010,
        ST_DONE   = 4'b0100,
        ST_ERROR  = 4'b1000
    } state_t;

    typedef enum logic [3:0] {
        NS_SKIP   = 4'b0001,
        NS_SIGN   = 4'b0010,
        NS_DIGITS = 4'b0100,
        NS_END    = 4'b1000
    } num_stage_t;

    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] phase_code(input state_t st);
        logic [1:0] p;
        unique case (st)
            ST_HEADER: p = PH_HEADER;
            ST_BODY:   p = PH_BODY;
            ST_DONE:   p = PH_DONE;
            ST_ERROR:  p = PH_ERROR;
            default:   p = PH_ERROR;
        endcase
        return p;
    endfunction

endpackage

>>> hw/rtl/hrlf_if.sv
interface hrlf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hrlf_out_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               phase;
    logic [1:0]               error_kind;
    logic                     is_payload;
    logic [8:0]               header_bytes;
    logic [30:0]              body_length;
    logic [30:0]              body_count;

    modport source (output valid, output phase, output error_kind, output is_payload,
                    output header_bytes, output body_length, output body_count,
                    input ready);
    modport sink   (input valid, input phase, input error_kind, input is_payload,
                    input header_bytes, input body_length, input body_count,
                    output ready);
endinterface

interface hrlf_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] max_content;

    modport source (output valid, output max_content, input ready);
    modport sink   (input valid, input max_content, output ready);
endinterface

>>> hw/rtl/http_response_length_framer.sv
// HTTP response framer by Content-Length.
// The din channel carries one response byte per beat. The header is counted
// and searched, case-insensitively, for the first "Content-Length:" ahead of
// any NUL byte; the decimal value after it is parsed with whitespace skipping,
// an optional sign and saturation. At CR LF CR LF the length is checked and
// the block moves on to count body bytes until the length is reached.
// The dout channel carries one result beat per input beat: phase, error kind,
// payload flag, header count, parsed length and body count after that byte.
// An accepted din beat is registered and shows on dout in the next cycle; one
// beat is taken every cycle while dout does not stall: all per-byte work is a
// single pass of matching, a times-ten shift-add and a few compares into the result register.
// The cfg channel writes max_content; it is always ready and should only be
// written while no beat is in flight.
// Reset returns the framer to the header phase with max_content at 65536.
// When the receiver stalls, the result register holds its beat and din
// still takes a new byte only in the cycle that beat leaves.
// Complete and error are sticky until reset.
module http_response_length_framer
(
    input  logic              clk,
    input  logic              rst_n,
    hrlf_in_if.sink           din,
    hrlf_out_if.source        dout,
    hrlf_cfg_if.sink          cfg
);

    // Configuration register.
    logic [hrlf_pkg::LEN_W-1:0]     max_content_reg;

    // Framer state.
    hrlf_pkg::state_t               state_reg, state_next;
    hrlf_pkg::err_t                 error_reg, error_next;
    logic [hrlf_pkg::HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [23:0]                    tail_reg, tail_next;
    logic [3:0]                     match_pos_reg, match_pos_next;
    logic                           match_found_reg, match_found_next;
    logic                           halted_reg, halted_next;
    hrlf_pkg::num_stage_t           num_stage_reg, num_stage_next;
    logic                           negative_reg, negative_next;
    logic                           digit_seen_reg, digit_seen_next;
    logic [hrlf_pkg::NUM_W-1:0]     num_value_reg, num_value_next;
    logic [hrlf_pkg::LEN_W-1:0]     length_reg, length_next;
    logic [hrlf_pkg::LEN_W-1:0]     body_cnt_reg, body_cnt_next;
    logic                           payload_next;

    // Result register.
    logic                           out_valid_reg;
    logic [1:0]                     out_phase_reg;
    logic [1:0]                     out_error_reg;
    logic                           out_payload_reg;
    logic [8:0]                     out_hdr_reg;
    logic [hrlf_pkg::LEN_W-1:0]     out_length_reg;
    logic [hrlf_pkg::LEN_W-1:0]     out_count_reg;

    logic                           accept;
    logic [7:0]                     b;
    logic [7:0]                     folded;
    logic                           is_digit;
    logic                           is_ws;
    logic [35:0]                    times_ten;
    logic [hrlf_pkg::NUM_W-1:0]     acc_value;
    logic                           hdr_end;
    logic [hrlf_pkg::LEN_W-1:0]     body_inc;

    // A new byte enters whenever the result register is empty or draining.
    assign din.ready = !out_valid_reg || dout.ready;
    assign accept    = din.valid && din.ready;
    assign cfg.ready = 1'b1;

    assign b        = din.data_byte;
    assign folded   = (b >= hrlf_pkg::CH_UP_A && b <= hrlf_pkg::CH_UP_Z) ?
                      (b + 8'd32) : b;
    assign is_digit = (b >= hrlf_pkg::CH_ZERO) && (b <= hrlf_pkg::CH_NINE);
    assign is_ws    = (b == hrlf_pkg::CH_SPACE) || (b == hrlf_pkg::CH_TAB) ||
                      (b == hrlf_pkg::CH_LF) || (b == hrlf_pkg::CH_VT) ||
                      (b == hrlf_pkg::CH_FF) || (b == hrlf_pkg::CH_CR);

    // value * 10 + digit as shift-add, saturating at all ones.
    assign times_ten = {1'b0, num_value_reg, 3'b000} + {3'b000, num_value_reg, 1'b0} +
                       {28'd0, b - hrlf_pkg::CH_ZERO};
    assign acc_value = (times_ten[35:32] != 4'd0) ? {hrlf_pkg::NUM_W{1'b1}} :
                       times_ten[31:0];

    assign hdr_end  = (tail_reg == hrlf_pkg::TAIL_CRLFCR) && (b == hrlf_pkg::CH_LF);
    assign body_inc = body_cnt_reg + 31'd1;

    always_comb
    begin
        state_next       = state_reg;
        error_next       = error_reg;
        hdr_cnt_next     = hdr_cnt_reg;
        tail_next        = tail_reg;
        match_pos_next   = match_pos_reg;
        match_found_next = match_found_reg;
        halted_next      = halted_reg;
        num_stage_next   = num_stage_reg;
        negative_next    = negative_reg;
        digit_seen_next  = digit_seen_reg;
        num_value_next   = num_value_reg;
        length_next      = length_reg;
        body_cnt_next    = body_cnt_reg;
        payload_next     = 1'b0;

        unique case (state_reg)
            hrlf_pkg::ST_HEADER:
            begin
                if (hdr_cnt_reg >= hrlf_pkg::HDR_LIMIT)
                begin
                    state_next = hrlf_pkg::ST_ERROR;
                    error_next = hrlf_pkg::ERR_HDR_LONG;
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + 1'b1;
                    tail_next    = {tail_reg[15:0], b};

                    if (match_found_reg)
                    begin
                        // Number parser after the key.
                        unique case (num_stage_reg)
                            hrlf_pkg::NS_SKIP:
                            begin
                                priority if (is_ws)
                                begin
                                    num_stage_next = hrlf_pkg::NS_SKIP;
                                end
                                else if (b == hrlf_pkg::CH_PLUS)
                                begin
                                    num_stage_next = hrlf_pkg::NS_SIGN;
                                end
                                else if (b == hrlf_pkg::CH_MINUS)
                                begin
                                    negative_next  = 1'b1;
                                    num_stage_next = hrlf_pkg::NS_SIGN;
                                end
                                else if (is_digit)
                                begin
                                    num_value_next  = acc_value;
                                    digit_seen_next = 1'b1;
                                    num_stage_next  = hrlf_pkg::NS_DIGITS;
                                end
                                else
                                begin
                                    num_stage_next = hrlf_pkg::NS_END;
                                end
                            end
                            hrlf_pkg::NS_SIGN,
                            hrlf_pkg::NS_DIGITS:
                            begin
                                if (is_digit)
                                begin
                                    num_value_next  = acc_value;
                                    digit_seen_next = 1'b1;
                                    num_stage_next  = hrlf_pkg::NS_DIGITS;
                                end
                                else
                                begin
                                    num_stage_next = hrlf_pkg::NS_END;
                                end
                            end
                            default:
                            begin
                                num_stage_next = num_stage_reg;
                            end
                        endcase
                    end
                    else if (!halted_reg)
                    begin
                        // Key search; a NUL stops it for good.
                        if (b == hrlf_pkg::CH_NUL)
                        begin
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            if (match_pos_reg < hrlf_pkg::KEY_LAST &&
                                folded == hrlf_pkg::key_char(match_pos_reg))
                            begin
                                match_pos_next = match_pos_reg + 1'b1;
                            end
                            else if (folded == hrlf_pkg::key_char(4'd0))
                            begin
                                match_pos_next = 4'd1;
                            end
                            else
                            begin
                                match_pos_next = 4'd0;
                            end
                            if (match_pos_next >= hrlf_pkg::KEY_LAST)
                            begin
                                match_found_next = 1'b1;
                            end
                        end
                    end

                    // The final LF cannot alter the key match or the parsed
                    // value, so the length check works on the stored values.
                    if (hdr_end)
                    begin
                        priority if (!match_found_reg)
                        begin
                            state_next = hrlf_pkg::ST_ERROR;
                            error_next = hrlf_pkg::ERR_LEN_MISSING;
                        end
                        else if (!digit_seen_reg ||
                                 (negative_reg && num_value_reg != '0) ||
                                 (num_value_reg > {1'b0, max_content_reg}))
                        begin
                            state_next = hrlf_pkg::ST_ERROR;
                            error_next = hrlf_pkg::ERR_LEN_INVALID;
                        end
                        else
                        begin
                            length_next = num_value_reg[hrlf_pkg::LEN_W-1:0];
                            state_next  = (num_value_reg == '0) ? hrlf_pkg::ST_DONE :
                                                                  hrlf_pkg::ST_BODY;
                        end
                    end
                end
            end
            hrlf_pkg::ST_BODY:
            begin
                body_cnt_next = body_inc;
                payload_next  = 1'b1;
                if (body_inc >= length_reg)
                begin
                    state_next = hrlf_pkg::ST_DONE;
                end
            end
            default:
            begin
                // Complete and error ignore further bytes.
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_content_reg <= hrlf_pkg::MAX_CONTENT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_content_reg <= cfg.max_content;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hrlf_pkg::ST_HEADER;
            error_reg       <= hrlf_pkg::ERR_NONE;
            hdr_cnt_reg     <= '0;
            tail_reg        <= '0;
            match_pos_reg   <= '0;
            match_found_reg <= 1'b0;
            halted_reg      <= 1'b0;
            num_stage_reg   <= hrlf_pkg::NS_SKIP;
            negative_reg    <= 1'b0;
            digit_seen_reg  <= 1'b0;
            num_value_reg   <= '0;
            length_reg      <= '0;
            body_cnt_reg    <= '0;
        end
        else if (accept)
        begin
            state_reg       <= state_next;
            error_reg       <= error_next;
            hdr_cnt_reg     <= hdr_cnt_next;
            tail_reg        <= tail_next;
            match_pos_reg   <= match_pos_next;
            match_found_reg <= match_found_next;
            halted_reg      <= halted_next;
            num_stage_reg   <= num_stage_next;
            negative_reg    <= negative_next;
            digit_seen_reg  <= digit_seen_next;
            num_value_reg   <= num_value_next;
            length_reg      <= length_next;
            body_cnt_reg    <= body_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_phase_reg   <= hrlf_pkg::phase_code(state_next);
            out_error_reg   <= error_next;
            out_payload_reg <= payload_next;
            out_hdr_reg     <= hdr_cnt_next[hrlf_pkg::HDR_OUT_W-1:0];
            out_length_reg  <= length_next;
            out_count_reg   <= body_cnt_next;
        end
    end

    assign dout.valid        = out_valid_reg;
    assign dout.phase        = out_phase_reg;
    assign dout.error_kind   = out_error_reg;
    assign dout.is_payload   = out_payload_reg;
    assign dout.header_bytes = out_hdr_reg;
    assign dout.body_length  = out_length_reg;
    assign dout.body_count   = out_count_reg;

    // An error kind is reported exactly when the phase is error.
    assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> ((dout.error_kind != hrlf_pkg::ERR_NONE) ==
                        (dout.phase == hrlf_pkg::PH_ERROR)))
        else $error("error kind and phase disagree");

    // Payload beats are only ever flagged once the header is over.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.is_payload) |-> (dout.phase != hrlf_pkg::PH_HEADER))
        else $error("payload flagged during header");

    // While in the body the count stays below the parsed length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.phase == hrlf_pkg::PH_BODY) |->
            (dout.body_count < dout.body_length))
        else $error("body count reached length without completing");

    // Error is sticky across further input beats.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && state_reg == hrlf_pkg::ST_ERROR) |=> (state_reg == hrlf_pkg::ST_ERROR))
        else $error("left the error phase");

endmodule
